FILE: hdl/sha1sh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the SHA-1 stream hasher.
// No dependencies; imported by sha1_stream_hasher_top.
package sha1sh_pkg;

   typedef logic [31:0] word_type;

   // Initial chaining values.
   localparam word_type INIT_H0 = 32'h67452301;
   localparam word_type INIT_H1 = 32'hEFCDAB89;
   localparam word_type INIT_H2 = 32'h98BADCFE;
   localparam word_type INIT_H3 = 32'h10325476;
   localparam word_type INIT_H4 = 32'hC3D2E1F0;

   // Round constants, one per group of twenty rounds.
   localparam word_type ROUND_K0 = 32'h5A827999;
   localparam word_type ROUND_K1 = 32'h6ED9EBA1;
   localparam word_type ROUND_K2 = 32'h8F1BBCDC;
   localparam word_type ROUND_K3 = 32'hCA62C1D6;

   // First padding byte and the offset where the length field starts.
   localparam logic [7:0] PAD_MARK       = 8'h80;
   localparam logic [5:0] LEN_OFFSET     = 6'd56;
   localparam logic [5:0] LAST_POS       = 6'd63;
   localparam logic [6:0] LAST_ROUND     = 7'd79;

   // Command codes carried in tuser.
   localparam logic CMD_ABSORB = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   function automatic word_type rotl1(input word_type x);
      return {x[30:0], x[31]};
   endfunction

   function automatic word_type rotl5(input word_type x);
      return {x[26:0], x[31:27]};
   endfunction

   function automatic word_type rotl30(input word_type x);
      return {x[1:0], x[31:2]};
   endfunction

endpackage

FILE: hdl/sha1_stream_hasher_top.sv
`timescale 1ns / 1ps
// SHA-1 stream hasher: byte-wide absorb, padding, 80-round compression.
// Depends on sha1sh_pkg for constants and rotate helpers.

// Message bytes enter only while the hasher is idle and are written into a
// 16 x 32-bit block memory. When the 64th byte of a block lands, the block is
// compressed: a load step issues the first memory read and loads the round
// registers, then 80 rounds run, then a fold step adds the result into the
// chaining words. Rounds 0 to 15 take their schedule word from the memory read
// port, later rounds from a 16-tap shift line. A finish command writes the
// padding one byte per cycle from the fill position to the end of the block
// and compresses, once or twice (twice when the fill position is 56 or more),
// then puts the digest in an output register and restarts from the initial
// chaining values. A new byte is accepted while the digest waits in that
// register; a second digest holds the block in its fold state until the first
// is taken. Only the low 32 bits of the bit length are encoded.
module sha1_stream_hasher_top
   import sha1sh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tuser,   // [0] command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata    // [31:0] digest_word0 .. [159:128] digest_word4
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD
   } state_type;

   state_type      state_ff;
   logic [28:0]    count_ff;
   logic [31:0]    bits_ff;
   logic           pad_mode_ff;
   logic           pad_first_ff;
   logic           pad_last_ff;
   logic [6:0]     round_ff;
   word_type       h_ff   [5];
   word_type       rr_ff  [5];
   word_type       win_ff [16];
   logic           rsp_valid_ff;
   logic [159:0]   rsp_data_ff;

   // Block memory and its registered read port.
   word_type       block_mem [16];
   word_type       rdata_ff;

   logic           req_fire;
   logic           digest_load;
   logic [5:0]     pos;
   logic           mem_we;
   logic [7:0]     mem_wbyte;
   logic [1:0]     mem_lane;
   logic [3:0]     mem_raddr;
   logic [7:0]     pad_byte;
   logic [1:0]     len_idx;
   word_type       w_sched;
   word_type       w_cur;
   word_type       f_val;
   word_type       k_val;
   word_type       t_in;
   word_type       fold  [5];

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign pos        = count_ff[5:0];

   // The final fold loads the digest once the output register is free.
   assign digest_load = (state_ff == ST_FOLD) && pad_mode_ff && pad_last_ff &&
                        (!rsp_valid_ff || rsp_tready);

   // Padding byte: marker first, length bytes at the tail of the final block.
   assign len_idx = ~pos[1:0];
   always_comb begin
      if (pad_first_ff) begin
         pad_byte = PAD_MARK;
      end else if (pad_last_ff && (pos >= 6'd60)) begin
         pad_byte = bits_ff[{len_idx, 3'b000} +: 8];
      end else begin
         pad_byte = 8'h00;
      end
   end

   // Byte write into the block memory, big-endian within each word.
   assign mem_we    = (req_fire && (req_tuser == CMD_ABSORB)) || (state_ff == ST_PAD);
   assign mem_wbyte = (state_ff == ST_PAD) ? pad_byte : req_tdata;
   assign mem_lane  = ~pos[1:0];

   // Read address runs one word ahead of the round that uses it.
   assign mem_raddr = (state_ff == ST_LOAD) ? 4'd0 : (round_ff[3:0] + 4'd1);

   // Writes and reads never conflict: the read data is only used during compression, when no writes happen.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         block_mem[pos[5:2]][{mem_lane, 3'b000} +: 8] <= mem_wbyte;
      end
      rdata_ff <= block_mem[mem_raddr];
   end

   // Message schedule and round function.
   assign w_sched = rotl1(win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0]);
   assign w_cur   = (round_ff < 7'd16) ? rdata_ff : w_sched;

   always_comb begin
      if (round_ff < 7'd20) begin
         f_val = (rr_ff[1] & rr_ff[2]) | (~rr_ff[1] & rr_ff[3]);
         k_val = ROUND_K0;
      end else if (round_ff < 7'd40) begin
         f_val = rr_ff[1] ^ rr_ff[2] ^ rr_ff[3];
         k_val = ROUND_K1;
      end else if (round_ff < 7'd60) begin
         f_val = (rr_ff[1] & rr_ff[2]) | (rr_ff[1] & rr_ff[3]) | (rr_ff[2] & rr_ff[3]);
         k_val = ROUND_K2;
      end else begin
         f_val = rr_ff[1] ^ rr_ff[2] ^ rr_ff[3];
         k_val = ROUND_K3;
      end
   end

   assign t_in = rotl5(rr_ff[0]) + f_val + rr_ff[4] + w_cur + k_val;

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         fold[i] = h_ff[i] + rr_ff[i];
      end
   end

   // Sequencer: state, counters, chaining words and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pad_mode_ff  <= 1'b0;
         pad_first_ff <= 1'b0;
         pad_last_ff  <= 1'b0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         h_ff[0]      <= INIT_H0;
         h_ff[1]      <= INIT_H1;
         h_ff[2]      <= INIT_H2;
         h_ff[3]      <= INIT_H3;
         h_ff[4]      <= INIT_H4;
      end else begin
         if (digest_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_tuser == CMD_ABSORB) begin
                     count_ff    <= count_ff + 29'd1;
                     pad_mode_ff <= 1'b0;
                     if (pos == LAST_POS) begin
                        state_ff <= ST_LOAD;
                     end
                  end else begin
                     bits_ff      <= {count_ff, 3'b000};
                     pad_mode_ff  <= 1'b1;
                     pad_first_ff <= 1'b1;
                     pad_last_ff  <= (pos < LEN_OFFSET);
                     state_ff     <= ST_PAD;
                  end
               end
            end

            ST_PAD: begin
               // One padding byte per cycle until the block is full.
               count_ff     <= {count_ff[28:6], pos + 6'd1};
               pad_first_ff <= 1'b0;
               if (pos == LAST_POS) begin
                  state_ff <= ST_LOAD;
               end
            end

            ST_LOAD: begin
               for (int i = 0; i < 5; i++) begin
                  rr_ff[i] <= h_ff[i];
               end
               round_ff <= '0;
               state_ff <= ST_ROUND;
            end

            ST_ROUND: begin
               rr_ff[4] <= rr_ff[3];
               rr_ff[3] <= rr_ff[2];
               rr_ff[2] <= rotl30(rr_ff[1]);
               rr_ff[1] <= rr_ff[0];
               rr_ff[0] <= t_in;
               for (int i = 0; i < 15; i++) begin
                  win_ff[i] <= win_ff[i + 1];
               end
               win_ff[15] <= w_cur;
               round_ff   <= round_ff + 7'd1;
               if (round_ff == LAST_ROUND) begin
                  state_ff <= ST_FOLD;
               end
            end

            ST_FOLD: begin
               if (!pad_mode_ff) begin
                  for (int i = 0; i < 5; i++) begin
                     h_ff[i] <= fold[i];
                  end
                  state_ff <= ST_IDLE;
               end else if (!pad_last_ff) begin
                  // Length did not fit: one more block of padding.
                  for (int i = 0; i < 5; i++) begin
                     h_ff[i] <= fold[i];
                  end
                  pad_last_ff <= 1'b1;
                  state_ff    <= ST_PAD;
               end else if (digest_load) begin
                  // Digest out, then restart the message.
                  rsp_data_ff  <= {fold[4], fold[3], fold[2], fold[1], fold[0]};
                  h_ff[0]      <= INIT_H0;
                  h_ff[1]      <= INIT_H1;
                  h_ff[2]      <= INIT_H2;
                  h_ff[3]      <= INIT_H3;
                  h_ff[4]      <= INIT_H4;
                  count_ff     <= '0;
                  pad_mode_ff  <= 1'b0;
                  pad_last_ff  <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
